FILE: hdl/rds_pkg.sv
`timescale 1ns / 1ps

package rds_pkg;

  localparam int DIGITS      = 4;
  localparam int DIGIT_CYCLE = 10;

  typedef logic [19:0] pos_t;     // Q4.16 wheel position
  typedef logic [3:0]  digit_t;   // one decimal digit
  typedef logic [13:0] target_t;  // display value
  typedef logic [16:0] ret_t;     // Q1.16 retention, 65536 = 1.0

  localparam pos_t    CYCLE_Q16       = 20'd655360;  // DIGIT_CYCLE in Q4.16
  localparam pos_t    THRESHOLD_RESET = 20'd327680;  // 5.0
  localparam target_t TARGET_MAX      = 14'd9999;    // 10^DIGITS - 1
  localparam ret_t    RET_ONE         = 17'd65536;
  localparam digit_t  WRAP_PIVOT      = 4'd5;

  // Reciprocal constants for the BCD split (exact over each stage's range)
  localparam logic [13:0] RECIP_1000 = 14'd8389;  // >> 23, v < 10000
  localparam logic [9:0]  RECIP_100  = 10'd41;    // >> 12, v < 1000
  localparam logic [7:0]  RECIP_10   = 8'd205;    // >> 11, v < 100

endpackage

FILE: hdl/rds_in_if.sv
`timescale 1ns / 1ps

interface rds_in_if;
  logic             valid;
  logic             ready;
  rds_pkg::target_t target_value;
  rds_pkg::ret_t    retention;

  modport source (output valid, output target_value, output retention, input ready);
  modport sink   (input valid, input target_value, input retention, output ready);
endinterface

FILE: hdl/rds_out_if.sv
`timescale 1ns / 1ps

interface rds_out_if;
  logic          valid;
  logic          ready;
  rds_pkg::pos_t digit_pos_0;
  rds_pkg::pos_t digit_pos_1;
  rds_pkg::pos_t digit_pos_2;
  rds_pkg::pos_t digit_pos_3;

  modport source (output valid, output digit_pos_0, output digit_pos_1,
                  output digit_pos_2, output digit_pos_3, input ready);
  modport sink   (input valid, input digit_pos_0, input digit_pos_1,
                  input digit_pos_2, input digit_pos_3, output ready);
endinterface

FILE: hdl/rds_cfg_if.sv
`timescale 1ns / 1ps

interface rds_cfg_if;
  logic          valid;
  logic          ready;
  rds_pkg::pos_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/rolling_digit_smoother.sv
`timescale 1ns / 1ps

// Rolling digit smoother: four decimal display wheels ease toward the digits
// of a target value.
// item   (sink)  : target_value (saturated to 9999) and retention (Q1.16,
//                  saturated to 1.0). One transfer per cycle unless stalled.
// result (source): digit_pos_0..3, Q4.16 wheel positions in [0, 10),
//                  thousands first. Exactly one result per item.
// cfg    (sink)  : route_threshold write, always ready; write only while idle.
// Path: an item is split into digits combinationally and registered in the
// input register; the blend then loads the wheels, which drive the result.
// Throughput: one item per cycle unless stalled. The rate is set by the wheel
// feedback loop: one 17x20 multiply, add and wrap per wheel between the input
// register and the wheel registers, which double as the output register.
// Stall: while the result is not taken the wheels hold, the input register
// keeps one item, and item.ready drops once that register is full.
// Reset (rst, synchronous): wheels go to 0.0, threshold to 5.0, no item or
// result pending.

module rolling_digit_smoother (
  input  logic          clk,
  input  logic          rst,
  rds_in_if.sink        item,
  rds_out_if.source     result,
  rds_cfg_if.sink       cfg
);

  // ---------------------------------------------------------------- split
  rds_pkg::target_t v_sat;
  rds_pkg::ret_t    r_sat;
  logic [27:0]      q3_prod;
  logic [15:0]      q2_prod;
  logic [14:0]      q1_prod;
  logic [9:0]       rem3;
  logic [6:0]       rem2;
  rds_pkg::digit_t  dig_in [rds_pkg::DIGITS];

  always_comb begin
    v_sat = (item.target_value > rds_pkg::TARGET_MAX) ? rds_pkg::TARGET_MAX
                                                      : item.target_value;
    r_sat = (item.retention > rds_pkg::RET_ONE) ? rds_pkg::RET_ONE : item.retention;

    // Thousands, hundreds, tens by reciprocal multiply; remainders feed down
    q3_prod   = 28'(v_sat) * 28'(rds_pkg::RECIP_1000);
    dig_in[0] = q3_prod[26:23];
    rem3      = 10'(v_sat - 14'(dig_in[0]) * 14'd1000);
    q2_prod   = 16'(rem3) * 16'(rds_pkg::RECIP_100);
    dig_in[1] = q2_prod[15:12];
    rem2      = 7'(rem3 - 10'(dig_in[1]) * 10'd100);
    q1_prod   = 15'(rem2) * 15'(rds_pkg::RECIP_10);
    dig_in[2] = q1_prod[14:11];
    dig_in[3] = 4'(rem2 - 7'(dig_in[2]) * 7'd10);
  end

  // ------------------------------------------------------ input register
  logic            s1_valid;
  rds_pkg::digit_t s1_digit [rds_pkg::DIGITS];
  rds_pkg::ret_t   s1_ret;
  rds_pkg::ret_t   s1_cret;   // 1.0 - r, precomputed
  logic            out_valid;
  logic            advance;

  assign advance    = s1_valid && (!out_valid || result.ready);
  assign item.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_digit <= dig_in;
      s1_ret   <= r_sat;
      s1_cret  <= rds_pkg::RET_ONE - r_sat;
    end
  end

  // ------------------------------------------------------- configuration
  rds_pkg::pos_t threshold;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= rds_pkg::THRESHOLD_RESET;
    end else if (cfg.valid) begin
      threshold <= cfg.data;
    end
  end

  // --------------------------------------------------------------- blend
  // new = floor(r*p / 2^16) + (1-r)*T, exact because the target term is a
  // whole multiple of 2^16. T is the digit, shifted by ten when the wheel is
  // farther than the threshold so it rolls the short way.
  function automatic rds_pkg::pos_t ease(input rds_pkg::pos_t p, input rds_pkg::digit_t d,
                                         input rds_pkg::ret_t r, input rds_pkg::ret_t cr,
                                         input rds_pkg::pos_t thr);
    logic signed [20:0] diff;
    logic [19:0]        span;
    logic signed [5:0]  tgt;
    logic [36:0]        prod;
    logic signed [23:0] keep;
    logic signed [23:0] pull;
    logic signed [23:0] blend;
    logic signed [23:0] cyc;
    logic signed [23:0] w;
    diff = $signed({1'b0, p}) - $signed({1'b0, d, 16'h0000});
    span = diff[20] ? 20'(-diff) : diff[19:0];
    tgt  = $signed({2'b00, d});
    if (span > thr) begin
      tgt = (d < rds_pkg::WRAP_PIVOT) ? tgt + 6'sd10 : tgt - 6'sd10;
    end
    prod  = 37'(r) * 37'(p);
    keep  = $signed({3'b000, prod[36:16]});
    pull  = $signed({7'b0000000, cr}) * $signed({{18{tgt[5]}}, tgt});
    blend = keep + pull;
    cyc   = $signed({4'b0000, rds_pkg::CYCLE_Q16});
    if (blend < 0) begin
      w = blend + cyc;
    end else if (blend >= cyc) begin
      w = blend - cyc;
    end else begin
      w = blend;
    end
    if (w < 0 || w >= cyc) begin
      w = '0;
    end
    return w[19:0];
  endfunction

  rds_pkg::pos_t wheel      [rds_pkg::DIGITS];
  rds_pkg::pos_t wheel_next [rds_pkg::DIGITS];

  always_comb begin
    for (int i = 0; i < rds_pkg::DIGITS; i++) begin
      wheel_next[i] = ease(wheel[i], s1_digit[i], s1_ret, s1_cret, threshold);
    end
  end

  // Wheels are the state and the output payload; they move only on advance,
  // which needs the output slot free or being taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rds_pkg::DIGITS; i++) begin
        wheel[i] <= '0;
      end
    end else if (advance) begin
      wheel <= wheel_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign result.valid       = out_valid;
  assign result.digit_pos_0 = wheel[0];
  assign result.digit_pos_1 = wheel[1];
  assign result.digit_pos_2 = wheel[2];
  assign result.digit_pos_3 = wheel[3];

  // ---------------------------------------------------------- assertions
  a_wheel_range: assert property (@(posedge clk) disable iff (rst)
    wheel[0] < rds_pkg::CYCLE_Q16 && wheel[1] < rds_pkg::CYCLE_Q16 &&
    wheel[2] < rds_pkg::CYCLE_Q16 && wheel[3] < rds_pkg::CYCLE_Q16)
    else $error("wheel position out of range");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.ready |=> $stable(wheel[0]) && $stable(wheel[1]) &&
                                    $stable(wheel[2]) && $stable(wheel[3]))
    else $error("wheel moved while result stalled");

  a_item_lands: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> s1_valid)
    else $error("transferred item lost from input register");

  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    cfg.valid && cfg.ready |=> threshold == $past(cfg.data))
    else $error("threshold write not taken");

endmodule
